FILE: hdl/hdq_pkg.sv
// Shared types, register map and reset values for the HDQ single-wire master.
package hdq_pkg;

   localparam int unsigned AddrWidth = 5;
   localparam int unsigned DataWidth = 32;

   // Register indexes on the configuration port (byte address is 4 * index).
   localparam logic [2:0] REG_BREAK_LOW     = 3'd0;
   localparam logic [2:0] REG_BREAK_RECOV   = 3'd1;
   localparam logic [2:0] REG_ONE_LOW       = 3'd2;
   localparam logic [2:0] REG_ZERO_LOW      = 3'd3;
   localparam logic [2:0] REG_BIT_PERIOD    = 3'd4;
   localparam logic [2:0] REG_READ_THRESH   = 3'd5;
   localparam logic [2:0] REG_READ_TIMEOUT  = 3'd6;
   localparam logic [2:0] REG_GAP           = 3'd7;

   localparam logic [9:0]  RST_BREAK_LOW    = 10'd210;
   localparam logic [9:0]  RST_BREAK_RECOV  = 10'd80;
   localparam logic [9:0]  RST_ONE_LOW      = 10'd35;
   localparam logic [9:0]  RST_ZERO_LOW     = 10'd139;
   localparam logic [9:0]  RST_BIT_PERIOD   = 10'd190;
   localparam logic [9:0]  RST_READ_THRESH  = 10'd70;
   localparam logic [15:0] RST_READ_TIMEOUT = 16'd2000;
   localparam logic [7:0]  RST_GAP          = 8'd3;

   // Item kinds on the input channel; the spare code is ignored by the block.
   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_READ  = 2'd1;
   localparam logic [1:0] KIND_WRITE = 2'd2;
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // Transaction phases.
   localparam logic [2:0] PH_IDLE   = 3'd0;
   localparam logic [2:0] PH_BREAK  = 3'd1;
   localparam logic [2:0] PH_ADDR   = 3'd2;
   localparam logic [2:0] PH_GAP    = 3'd3;
   localparam logic [2:0] PH_DATA   = 3'd4;
   localparam logic [2:0] PH_RXFALL = 3'd5;
   localparam logic [2:0] PH_RXLOW  = 3'd6;

   typedef struct packed {
      logic [9:0]  break_low_us;
      logic [9:0]  break_recovery_us;
      logic [9:0]  one_low_us;
      logic [9:0]  zero_low_us;
      logic [9:0]  bit_period_us;
      logic [9:0]  read_threshold_us;
      logic [15:0] read_timeout_us;
      logic [7:0]  gap_us;
   } hdq_cfg_type;

endpackage

FILE: hdl/hdq_single_wire_master.sv
// HDQ single-wire master: each input item that is accepted yields one result item.
// Throughput is one item per cycle while rsp_stall does not hold the result; the transaction
// state advances once per item in a single registered step between the input register and
// the result register. Synchronous active-high reset idles the state machine, empties both
// registers and restores every timing register to its default value.
module hdq_single_wire_master (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_kind,
   input  logic [6:0]                      req_address,
   input  logic [7:0]                      req_write_data,
   input  logic                            req_line_in,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_line_release,
   output logic                            rsp_busy_res,
   output logic                            rsp_done_res,
   output logic [7:0]                      rsp_read_data,
   output logic                            rsp_timed_out,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hdq_pkg::AddrWidth-1:0]   paddr,
   input  logic [hdq_pkg::DataWidth-1:0]   pwdata,
   output logic [hdq_pkg::DataWidth-1:0]   prdata,
   output logic                            pready
);
   import hdq_pkg::*;

   hdq_cfg_type cfg;

   hdq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hdq_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .req_line_in      (req_line_in),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_line_release (rsp_line_release),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_done_res     (rsp_done_res),
      .rsp_read_data    (rsp_read_data),
      .rsp_timed_out    (rsp_timed_out)
   );

endmodule

FILE: hdl/hdq_csr.sv
// APB-style configuration register file for the HDQ master timing values.
module hdq_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [hdq_pkg::AddrWidth-1:0]   paddr,
   input  logic [hdq_pkg::DataWidth-1:0]   pwdata,
   output logic [hdq_pkg::DataWidth-1:0]   prdata,
   output logic                            pready,
   output hdq_pkg::hdq_cfg_type            cfg
);
   import hdq_pkg::*;

   hdq_cfg_type cfg_ff;
   hdq_cfg_type cfg_in;
   logic [2:0]  reg_index;
   logic        wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[AddrWidth-1:2];
   assign wr_en     = psel && penable && pwrite && pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_index)
            REG_BREAK_LOW:    cfg_in.break_low_us      = pwdata[9:0];
            REG_BREAK_RECOV:  cfg_in.break_recovery_us = pwdata[9:0];
            REG_ONE_LOW:      cfg_in.one_low_us        = pwdata[9:0];
            REG_ZERO_LOW:     cfg_in.zero_low_us       = pwdata[9:0];
            REG_BIT_PERIOD:   cfg_in.bit_period_us     = pwdata[9:0];
            REG_READ_THRESH:  cfg_in.read_threshold_us = pwdata[9:0];
            REG_READ_TIMEOUT: cfg_in.read_timeout_us   = pwdata[15:0];
            REG_GAP:          cfg_in.gap_us            = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.break_low_us      <= RST_BREAK_LOW;
         cfg_ff.break_recovery_us <= RST_BREAK_RECOV;
         cfg_ff.one_low_us        <= RST_ONE_LOW;
         cfg_ff.zero_low_us       <= RST_ZERO_LOW;
         cfg_ff.bit_period_us     <= RST_BIT_PERIOD;
         cfg_ff.read_threshold_us <= RST_READ_THRESH;
         cfg_ff.read_timeout_us   <= RST_READ_TIMEOUT;
         cfg_ff.gap_us            <= RST_GAP;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_index)
         REG_BREAK_LOW:    prdata = {22'd0, cfg_ff.break_low_us};
         REG_BREAK_RECOV:  prdata = {22'd0, cfg_ff.break_recovery_us};
         REG_ONE_LOW:      prdata = {22'd0, cfg_ff.one_low_us};
         REG_ZERO_LOW:     prdata = {22'd0, cfg_ff.zero_low_us};
         REG_BIT_PERIOD:   prdata = {22'd0, cfg_ff.bit_period_us};
         REG_READ_THRESH:  prdata = {22'd0, cfg_ff.read_threshold_us};
         REG_READ_TIMEOUT: prdata = {16'd0, cfg_ff.read_timeout_us};
         REG_GAP:          prdata = {24'd0, cfg_ff.gap_us};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/hdq_engine.sv
// Input register, HDQ transaction state machine and result register.
module hdq_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  hdq_pkg::hdq_cfg_type cfg,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [1:0]           req_kind,
   input  logic [6:0]           req_address,
   input  logic [7:0]           req_write_data,
   input  logic                 req_line_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_line_release,
   output logic                 rsp_busy_res,
   output logic                 rsp_done_res,
   output logic [7:0]           rsp_read_data,
   output logic                 rsp_timed_out
);
   import hdq_pkg::*;

   // Input register.
   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [6:0] in_address_ff;
   logic [7:0] in_wdata_ff;
   logic       in_line_ff;

   // Transaction state.
   logic [2:0]  phase_ff,      phase_in;
   logic [3:0]  bit_count_ff,  bit_count_in;
   logic [15:0] time_count_ff, time_count_in;
   logic [15:0] low_count_ff,  low_count_in;
   logic [7:0]  shift_out_ff,  shift_out_in;
   logic [7:0]  data_hold_ff,  data_hold_in;
   logic [7:0]  shift_in_ff,   shift_in_in;
   logic        is_write_ff,   is_write_in;

   // Result register.
   logic        out_valid_ff;
   logic        release_ff, release_in;
   logic        busy_ff,    busy_in;
   logic        done_ff,    done_in;
   logic [7:0]  rdata_ff,   rdata_in;
   logic        tout_ff,    tout_in;

   logic        advance;
   logic [15:0] time_inc;
   logic [3:0]  bit_inc;
   logic [9:0]  low_cur;
   logic [10:0] bit_end;
   logic [10:0] break_end;
   logic [9:0]  low_next;
   logic [7:0]  rx_shifted;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_kind_ff    <= req_kind;
         in_address_ff <= req_address;
         in_wdata_ff   <= req_write_data;
         in_line_ff    <= req_line_in;
      end
   end

   assign time_inc  = (time_count_ff == 16'hFFFF) ? time_count_ff : time_count_ff + 16'd1;
   assign bit_inc   = bit_count_ff + 4'd1;
   assign low_cur   = shift_out_ff[0] ? cfg.one_low_us : cfg.zero_low_us;
   // A low time that fills the whole period still leaves one released microsecond.
   assign bit_end   = (cfg.bit_period_us > low_cur) ? {1'b0, cfg.bit_period_us}
                                                    : {1'b0, low_cur} + 11'd1;
   assign break_end = {1'b0, cfg.break_low_us} + {1'b0, cfg.break_recovery_us};
   assign rx_shifted = {(low_count_ff <= {6'd0, cfg.read_threshold_us}), shift_in_ff[7:1]};

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      time_count_in = time_count_ff;
      low_count_in  = low_count_ff;
      shift_out_in  = shift_out_ff;
      data_hold_in  = data_hold_ff;
      shift_in_in   = shift_in_ff;
      is_write_in   = is_write_ff;
      done_in       = 1'b0;
      tout_in       = 1'b0;
      rdata_in      = 8'd0;

      if (in_kind_ff == KIND_READ || in_kind_ff == KIND_WRITE) begin
         if (phase_ff == PH_IDLE) begin
            is_write_in   = (in_kind_ff == KIND_WRITE);
            shift_out_in  = {(in_kind_ff == KIND_WRITE), in_address_ff};
            data_hold_in  = in_wdata_ff;
            shift_in_in   = 8'd0;
            bit_count_in  = 4'd0;
            time_count_in = 16'd0;
            low_count_in  = 16'd0;
            phase_in      = PH_BREAK;
         end
      end else if (in_kind_ff == KIND_TICK) begin
         case (phase_ff)
            PH_BREAK: begin
               time_count_in = time_inc;
               if (time_inc >= {5'd0, break_end}) begin
                  phase_in      = PH_ADDR;
                  time_count_in = 16'd0;
                  bit_count_in  = 4'd0;
               end
            end
            PH_ADDR, PH_DATA: begin
               time_count_in = time_inc;
               if (time_inc >= {5'd0, bit_end}) begin
                  shift_out_in  = {1'b0, shift_out_ff[7:1]};
                  bit_count_in  = bit_inc;
                  time_count_in = 16'd0;
                  if (bit_inc >= 4'd8) begin
                     if (phase_ff == PH_DATA) begin
                        phase_in     = PH_IDLE;
                        bit_count_in = 4'd0;
                        done_in      = 1'b1;
                     end else if (cfg.gap_us == 8'd0) begin
                        bit_count_in = 4'd0;
                        if (is_write_ff) begin
                           phase_in     = PH_DATA;
                           shift_out_in = data_hold_ff;
                        end else begin
                           phase_in    = PH_RXFALL;
                           shift_in_in = 8'd0;
                        end
                     end else begin
                        phase_in = PH_GAP;
                     end
                  end
               end
            end
            PH_GAP: begin
               time_count_in = time_inc;
               if (time_inc >= {8'd0, cfg.gap_us}) begin
                  time_count_in = 16'd0;
                  bit_count_in  = 4'd0;
                  if (is_write_ff) begin
                     phase_in     = PH_DATA;
                     shift_out_in = data_hold_ff;
                  end else begin
                     phase_in    = PH_RXFALL;
                     shift_in_in = 8'd0;
                  end
               end
            end
            PH_RXFALL: begin
               if (!in_line_ff) begin
                  phase_in     = PH_RXLOW;
                  low_count_in = 16'd1;
               end else begin
                  time_count_in = time_inc;
                  if (time_inc >= cfg.read_timeout_us) begin
                     phase_in      = PH_IDLE;
                     time_count_in = 16'd0;
                     bit_count_in  = 4'd0;
                     done_in       = 1'b1;
                     tout_in       = 1'b1;
                  end
               end
            end
            PH_RXLOW: begin
               if (!in_line_ff) begin
                  if (low_count_ff != 16'hFFFF) begin
                     low_count_in = low_count_ff + 16'd1;
                  end
               end else begin
                  shift_in_in   = rx_shifted;
                  bit_count_in  = bit_inc;
                  time_count_in = 16'd0;
                  if (bit_inc >= 4'd8) begin
                     phase_in     = PH_IDLE;
                     bit_count_in = 4'd0;
                     done_in      = 1'b1;
                     rdata_in     = rx_shifted;
                  end else begin
                     phase_in = PH_RXFALL;
                  end
               end
            end
            default: begin
               phase_in = phase_ff;
            end
         endcase
      end
   end

   // The line level and busy flag reflect the state after this item.
   assign low_next = shift_out_in[0] ? cfg.one_low_us : cfg.zero_low_us;

   always_comb begin
      if (phase_in == PH_BREAK) begin
         release_in = !(time_count_in < {6'd0, cfg.break_low_us});
      end else if (phase_in == PH_ADDR || phase_in == PH_DATA) begin
         release_in = !(time_count_in < {6'd0, low_next});
      end else begin
         release_in = 1'b1;
      end
   end

   assign busy_in = (phase_in != PH_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         time_count_ff <= 16'd0;
         low_count_ff  <= 16'd0;
         shift_out_ff  <= 8'd0;
         data_hold_ff  <= 8'd0;
         shift_in_ff   <= 8'd0;
         is_write_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         time_count_ff <= time_count_in;
         low_count_ff  <= low_count_in;
         shift_out_ff  <= shift_out_in;
         data_hold_ff  <= data_hold_in;
         shift_in_ff   <= shift_in_in;
         is_write_ff   <= is_write_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         release_ff <= release_in;
         busy_ff    <= busy_in;
         done_ff    <= done_in;
         rdata_ff   <= rdata_in;
         tout_ff    <= tout_in;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_line_release = release_ff;
   assign rsp_busy_res     = busy_ff;
   assign rsp_done_res     = done_ff;
   assign rsp_read_data    = rdata_ff;
   assign rsp_timed_out    = tout_ff;

endmodule
